// ===== src/csv_field_splitter_assert.svh =====
// Assertion macros used by the checker file of the CSV field splitter.
`ifndef CSV_FIELD_SPLITTER_ASSERT_SVH
`define CSV_FIELD_SPLITTER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CSVFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csv_field_splitter assertion failed");

// Consequent checked in the cycle after the antecedent.
`define CSVFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csv_field_splitter assertion failed");

`endif

// ===== src/csvfs_pkg.sv =====
package csvfs_pkg;

    localparam logic [2:0] ST_START  = 3'd0;
    localparam logic [2:0] ST_PLAIN  = 3'd1;
    localparam logic [2:0] ST_QUOTED = 3'd2;
    localparam logic [2:0] ST_QSEEN  = 3'd3;
    localparam logic [2:0] ST_TAIL   = 3'd4;

    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_COMMA = 8'd44;

    localparam logic [1:0] CFG_SEPARATOR  = 2'd0;
    localparam logic [1:0] CFG_NL_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_NL_FIRST   = 2'd2;
    localparam logic [1:0] CFG_NL_SECOND  = 2'd3;

    localparam logic [1:0] NL_LENGTH_RESET = 2'd2;

    typedef struct packed {
        logic has_char;
        logic field_end;
        logic record_end;
        logic last_of_run;
    } t_marks;

endpackage

// ===== src/csv_field_splitter.sv =====
// CSV field splitter.
// The input stream carries one text character per transaction in tdata; tlast marks the
// end of the text and closes any open field and record, then clears the record count.
// The output stream carries one field character, or an end mark without a character,
// per transaction; tuser flags a present character, a field end and a record end, and
// tlast marks the last result of one input transaction. tdata also holds the 1-based
// record number, which saturates at its maximum.
// The user must write separator, newline string length and its two characters over the
// always-ready configuration channel only while the block is idle (not enforced).
// An accepted character enters an input register and is parsed once the output queue has
// room; its results are written into the output queue, from which the output is driven.
// The parser takes one character per cycle while the queue has room; a line break or the
// end of text inside quotes can give two results, and the four-entry output queue then
// drains at one result per cycle while the receiver is ready.
// Reset returns the parser to field start, clears the record count and empties both the
// input register and the output queue; configuration returns to comma, CR LF.
// When the receiver stalls, results wait in the output queue; the input side keeps
// accepting until the queue has room for fewer than two results.
module csv_field_splitter #(
    parameter int CHAR_BITS  = 16,
    parameter int COUNT_BITS = 32,
    localparam int IN_BITS   = ((CHAR_BITS + 7) / 8) * 8,
    localparam int DATA_BITS = ((CHAR_BITS + COUNT_BITS + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_BITS-1:0]   i_s_tdata,   // in_char
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [DATA_BITS-1:0] o_m_tdata,   // out_char, record_number
    output logic [2:0]           o_m_tuser,   // has_char, field_end, record_end
    output logic                 o_m_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [CHAR_BITS-1:0] i_cfg_data
);
    import csvfs_pkg::*;

    logic [CHAR_BITS-1:0]  r_sep;
    logic [1:0]            r_nl_len;
    logic [CHAR_BITS-1:0]  r_nl_first;
    logic [CHAR_BITS-1:0]  r_nl_second;

    logic                  r_in_valid;
    logic [CHAR_BITS-1:0]  r_in_char;
    logic                  r_in_eot;

    logic                  in_accept;
    logic                  take;
    logic                  room;
    logic [1:0]            num;
    t_marks                marks0;
    t_marks                marks1;
    logic [CHAR_BITS-1:0]  char0;
    logic [CHAR_BITS-1:0]  char1;
    logic [COUNT_BITS-1:0] number;
    t_marks                q_marks;
    logic [CHAR_BITS-1:0]  q_char;
    logic [COUNT_BITS-1:0] q_number;

    assign o_cfg_ready = 1'b1;
    assign take        = r_in_valid && room;
    assign o_s_tready  = !r_in_valid || take;
    assign in_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep       <= CHAR_BITS'(CH_COMMA);
            r_nl_len    <= NL_LENGTH_RESET;
            r_nl_first  <= CHAR_BITS'(CH_CR);
            r_nl_second <= CHAR_BITS'(CH_LF);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SEPARATOR: r_sep       <= i_cfg_data;
                CFG_NL_LENGTH: r_nl_len    <= i_cfg_data[1:0];
                CFG_NL_FIRST:  r_nl_first  <= i_cfg_data;
                CFG_NL_SECOND: r_nl_second <= i_cfg_data;
                default:       r_sep       <= r_sep;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char <= i_s_tdata[CHAR_BITS-1:0];
            r_in_eot  <= i_s_tlast;
        end
    end

    csvfs_parser #(
        .CHAR_BITS  (CHAR_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_char      (r_in_char),
        .i_eot       (r_in_eot),
        .i_sep       (r_sep),
        .i_nl_len    (r_nl_len),
        .i_nl_first  (r_nl_first),
        .i_nl_second (r_nl_second),
        .o_num       (num),
        .o_marks0    (marks0),
        .o_marks1    (marks1),
        .o_char0     (char0),
        .o_char1     (char1),
        .o_number    (number)
    );

    csvfs_out_queue #(
        .CHAR_BITS  (CHAR_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_out_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_num (take ? num : 2'd0),
        .i_marks0 (marks0),
        .i_marks1 (marks1),
        .i_char0  (char0),
        .i_char1  (char1),
        .i_number (number),
        .o_room   (room),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_marks  (q_marks),
        .o_char   (q_char),
        .o_number (q_number)
    );

    assign o_m_tdata = DATA_BITS'({q_number, q_char});
    assign o_m_tuser = {q_marks.record_end, q_marks.field_end, q_marks.has_char};
    assign o_m_tlast = q_marks.last_of_run;

endmodule

// ===== src/csvfs_parser.sv =====
module csvfs_parser #(
    parameter int CHAR_BITS  = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [CHAR_BITS-1:0]  i_char,
    input  logic                  i_eot,
    input  logic [CHAR_BITS-1:0]  i_sep,
    input  logic [1:0]            i_nl_len,
    input  logic [CHAR_BITS-1:0]  i_nl_first,
    input  logic [CHAR_BITS-1:0]  i_nl_second,
    output logic [1:0]            o_num,
    output csvfs_pkg::t_marks     o_marks0,
    output csvfs_pkg::t_marks     o_marks1,
    output logic [CHAR_BITS-1:0]  o_char0,
    output logic [CHAR_BITS-1:0]  o_char1,
    output logic [COUNT_BITS-1:0] o_number
);
    import csvfs_pkg::*;

    logic [2:0]            r_state;
    logic                  r_skip_lf;
    logic                  r_rec_open;
    logic                  r_line_broken;
    logic [COUNT_BITS-1:0] r_count;

    logic [2:0]            n_state;
    logic                  n_skip_lf;
    logic                  n_rec_open;
    logic                  n_line_broken;
    logic [COUNT_BITS-1:0] n_count;

    logic [COUNT_BITS-1:0] count_inc;
    logic                  is_quote;
    logic                  is_sep;
    logic                  is_cr;
    logic                  is_lf;
    logic                  close_nl;

    assign count_inc = (r_count == {COUNT_BITS{1'b1}}) ? r_count : r_count + 1'b1;
    assign is_quote  = (i_char == CHAR_BITS'(CH_QUOTE));
    assign is_sep    = (i_char == i_sep);
    assign is_cr     = (i_char == CHAR_BITS'(CH_CR));
    assign is_lf     = (i_char == CHAR_BITS'(CH_LF));

    always_comb begin
        n_state       = r_state;
        n_skip_lf     = r_skip_lf;
        n_rec_open    = r_rec_open;
        n_line_broken = r_line_broken;
        n_count       = r_count;
        o_num         = 2'd0;
        o_marks0      = '0;
        o_marks1      = '0;
        o_char0       = '0;
        o_char1       = '0;
        o_number      = r_count;
        close_nl      = 1'b0;

        if (i_eot) begin
            if (r_rec_open) begin
                if (r_state == ST_QUOTED && !r_line_broken) begin
                    close_nl = 1'b1;
                end else begin
                    o_num               = 2'd1;
                    o_marks0.field_end  = 1'b1;
                    o_marks0.record_end = 1'b1;
                end
            end
            n_state       = ST_START;
            n_skip_lf     = 1'b0;
            n_rec_open    = 1'b0;
            n_line_broken = 1'b0;
            n_count       = '0;
        end else if (r_skip_lf && is_lf) begin
            n_skip_lf = 1'b0;
        end else begin
            n_skip_lf = 1'b0;
            if (is_cr || is_lf) begin
                n_skip_lf = is_cr;
                if (!r_rec_open) begin
                    n_count             = count_inc;
                    o_number            = count_inc;
                    o_num               = 2'd1;
                    o_marks0.record_end = 1'b1;
                end else if (r_state == ST_QUOTED) begin
                    n_line_broken = 1'b1;
                    unique case (i_nl_len)
                        2'd0: begin
                            o_num = 2'd0;
                        end
                        2'd1: begin
                            o_num             = 2'd1;
                            o_marks0.has_char = 1'b1;
                            o_char0           = i_nl_first;
                        end
                        default: begin
                            o_num             = 2'd2;
                            o_marks0.has_char = 1'b1;
                            o_char0           = i_nl_first;
                            o_marks1.has_char = 1'b1;
                            o_char1           = i_nl_second;
                        end
                    endcase
                end else begin
                    o_num               = 2'd1;
                    o_marks0.field_end  = 1'b1;
                    o_marks0.record_end = 1'b1;
                    n_rec_open          = 1'b0;
                    n_state             = ST_START;
                end
            end else begin
                if (!r_rec_open) begin
                    n_count    = count_inc;
                    o_number   = count_inc;
                    n_rec_open = 1'b1;
                end
                n_line_broken = 1'b0;
                unique case (r_state)
                    ST_START: begin
                        if (is_quote) begin
                            n_state = ST_QUOTED;
                        end else if (is_sep) begin
                            o_num              = 2'd1;
                            o_marks0.field_end = 1'b1;
                        end else begin
                            o_num             = 2'd1;
                            o_marks0.has_char = 1'b1;
                            o_char0           = i_char;
                            n_state           = ST_PLAIN;
                        end
                    end
                    ST_QUOTED: begin
                        if (is_quote) begin
                            n_state = ST_QSEEN;
                        end else begin
                            o_num             = 2'd1;
                            o_marks0.has_char = 1'b1;
                            o_char0           = i_char;
                        end
                    end
                    ST_QSEEN: begin
                        if (is_quote) begin
                            o_num             = 2'd1;
                            o_marks0.has_char = 1'b1;
                            o_char0           = i_char;
                            n_state           = ST_QUOTED;
                        end else if (is_sep) begin
                            o_num              = 2'd1;
                            o_marks0.field_end = 1'b1;
                            n_state            = ST_START;
                        end else begin
                            o_num             = 2'd1;
                            o_marks0.has_char = 1'b1;
                            o_char0           = i_char;
                            n_state           = ST_TAIL;
                        end
                    end
                    default: begin
                        if (is_sep) begin
                            o_num              = 2'd1;
                            o_marks0.field_end = 1'b1;
                            n_state            = ST_START;
                        end else begin
                            o_num             = 2'd1;
                            o_marks0.has_char = 1'b1;
                            o_char0           = i_char;
                        end
                    end
                endcase
            end
        end

        // Closing newline string at end of text inside quotes.
        if (close_nl) begin
            unique case (i_nl_len)
                2'd0: begin
                    o_num               = 2'd1;
                    o_marks0.field_end  = 1'b1;
                    o_marks0.record_end = 1'b1;
                end
                2'd1: begin
                    o_num               = 2'd1;
                    o_marks0.has_char   = 1'b1;
                    o_char0             = i_nl_first;
                    o_marks0.field_end  = 1'b1;
                    o_marks0.record_end = 1'b1;
                end
                default: begin
                    o_num               = 2'd2;
                    o_marks0.has_char   = 1'b1;
                    o_char0             = i_nl_first;
                    o_marks1.has_char   = 1'b1;
                    o_char1             = i_nl_second;
                    o_marks1.field_end  = 1'b1;
                    o_marks1.record_end = 1'b1;
                end
            endcase
        end

        o_marks0.last_of_run = (o_num == 2'd1);
        o_marks1.last_of_run = (o_num == 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_START;
            r_skip_lf     <= 1'b0;
            r_rec_open    <= 1'b0;
            r_line_broken <= 1'b0;
            r_count       <= '0;
        end else if (i_take) begin
            r_state       <= n_state;
            r_skip_lf     <= n_skip_lf;
            r_rec_open    <= n_rec_open;
            r_line_broken <= n_line_broken;
            r_count       <= n_count;
        end
    end

endmodule

// ===== src/csvfs_out_queue.sv =====
module csvfs_out_queue #(
    parameter int CHAR_BITS  = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_wr_num,
    input  csvfs_pkg::t_marks     i_marks0,
    input  csvfs_pkg::t_marks     i_marks1,
    input  logic [CHAR_BITS-1:0]  i_char0,
    input  logic [CHAR_BITS-1:0]  i_char1,
    input  logic [COUNT_BITS-1:0] i_number,
    output logic                  o_room,
    output logic                  o_valid,
    input  logic                  i_ready,
    output csvfs_pkg::t_marks     o_marks,
    output logic [CHAR_BITS-1:0]  o_char,
    output logic [COUNT_BITS-1:0] o_number
);
    import csvfs_pkg::*;

    t_marks                r_marks [4];
    logic [CHAR_BITS-1:0]  r_char  [4];
    logic [COUNT_BITS-1:0] r_num   [4];
    logic [1:0]            r_wr_ptr;
    logic [1:0]            r_rd_ptr;
    logic [2:0]            r_fill;
    logic                  pop;
    logic [1:0]            wr_ptr1;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_fill != 3'd0);
    assign o_room  = (r_fill <= 3'd2);
    assign wr_ptr1 = r_wr_ptr + 2'd1;
    assign o_marks  = r_marks[r_rd_ptr];
    assign o_char   = r_char[r_rd_ptr];
    assign o_number = r_num[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr_num != 2'd0) begin
            r_marks[r_wr_ptr] <= i_marks0;
            r_char[r_wr_ptr]  <= i_char0;
            r_num[r_wr_ptr]   <= i_number;
        end
        if (i_wr_num == 2'd2) begin
            r_marks[wr_ptr1] <= i_marks1;
            r_char[wr_ptr1]  <= i_char1;
            r_num[wr_ptr1]   <= i_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + i_wr_num;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_fill <= r_fill + {1'b0, i_wr_num} - {2'b00, pop};
        end
    end

endmodule

// ===== src/csv_field_splitter_checker.sv =====
`include "csv_field_splitter_assert.svh"

module csv_field_splitter_checker #(
    parameter int CHAR_BITS  = 16,
    parameter int COUNT_BITS = 32,
    localparam int DATA_BITS = ((CHAR_BITS + COUNT_BITS + 7) / 8) * 8
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_m_tvalid,
    input logic                 i_m_tready,
    input logic [DATA_BITS-1:0] i_m_tdata,
    input logic [2:0]           i_m_tuser,
    input logic                 i_m_tlast
);

    `CSVFS_ASSERT_NEXT(a_valid_holds, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid)

    `CSVFS_ASSERT_NEXT(a_payload_holds, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast))

    `CSVFS_ASSERT_NOW(a_no_char_is_zero, i_clk, i_rst_n, i_m_tvalid && !i_m_tuser[0], i_m_tdata[CHAR_BITS-1:0] == '0)

    `CSVFS_ASSERT_NOW(a_no_char_has_mark, i_clk, i_rst_n, i_m_tvalid && !i_m_tuser[0], i_m_tuser[1] || i_m_tuser[2])

endmodule

bind csv_field_splitter csv_field_splitter_checker #(
    .CHAR_BITS  (CHAR_BITS),
    .COUNT_BITS (COUNT_BITS)
) u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);
